// File: rtl/b64fnv_pkg.sv
// ----------------------------------------------------------------------------
// b64fnv_pkg
// shared types, constants and the base64 alphabet lookup for the digest core
// ----------------------------------------------------------------------------
package b64fnv_pkg;

    typedef logic [63:0] hash_t;
    typedef logic [7:0]  char_t;
    typedef logic [5:0]  sextet_t;

    localparam hash_t FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam char_t PAD_CHAR  = 8'h3D;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic char_t b64_char(input sextet_t s);
        char_t c;
        if (s < 6'd26)
            c = 8'h41 + {2'b00, s};
        else if (s < 6'd52)
            c = 8'h61 + {2'b00, s} - 8'd26;
        else if (s < 6'd62)
            c = 8'h30 + {2'b00, s} - 8'd52;
        else if (s == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

endpackage

// File: rtl/base64_encode_fnv1a_digest_core.sv
// ----------------------------------------------------------------------------
// base64_encode_fnv1a_digest_core
// streaming base64 encoder whose characters feed a 64-bit fnv-1a digest
// ----------------------------------------------------------------------------
// Bytes arrive one word at a time. Up to two bytes are held until a group of
// three completes; a completed group, or the padded tail on an end-of-message
// word, becomes four base64 characters that one shared fnv-1a round unit
// folds into the hash, one character per cycle. A word that produces no
// characters is absorbed without fold rounds. A word that produces
// characters is accepted and then folded in four rounds, and an
// end-of-message word then has the digest moved into the output register,
// after which the hash returns to the offset basis. The round unit sets the
// pace: the input stalls while it folds, so no new byte is taken until the
// rounds of the last group are through. The digest waits in its own
// register, so a new message can start while it is still stalled
// downstream. An end-of-message word that opens a message with no byte
// yields the offset basis.
// ----------------------------------------------------------------------------
module base64_encode_fnv1a_digest_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              byte_present,
    input  logic              end_of_message,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [63:0]       digest
);
    import b64fnv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FOLD = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] pend_reg, pend_next;     // waiting bytes, first in the top half
    logic [1:0]  pcnt_reg, pcnt_next;     // number of waiting bytes
    hash_t       hash_reg, hash_next;
    char_t       chars_reg [4];
    char_t       chars_next [4];
    logic [1:0]  idx_reg, idx_next;       // which character the round unit folds
    logic        emit_reg, emit_next;     // digest goes out after the rounds
    logic        out_valid_reg, out_valid_next;
    hash_t       digest_reg, digest_next;

    hash_t       fold_hash;
    logic        in_acc;
    logic        out_free;
    logic        load_out;
    logic [1:0]  nb;                      // bytes in hand including this word
    logic [7:0]  x0, x1, x2;
    logic        grp_full;
    logic        has_chars;

    b64fnv_fold u_fold (
        .hash_in  (hash_reg),
        .char_in  (chars_reg[idx_reg]),
        .hash_out (fold_hash)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == S_HOLD) && out_free;
    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;

    // gather the group: older pending bytes first, then the incoming byte
    always_comb
    begin
        nb = pcnt_reg + {1'b0, byte_present};
        x0 = (pcnt_reg != 2'd0) ? pend_reg[15:8] : data_byte;
        x1 = (pcnt_reg == 2'd2) ? pend_reg[7:0]  : data_byte;
        x2 = data_byte;
        grp_full  = (nb == 2'd3);
        has_chars = grp_full || (end_of_message && (nb != 2'd0));

        // one or two leftover bytes get zero-filled sextets and '=' padding
        chars_next[0] = b64_char(x0[7:2]);
        chars_next[1] = b64_char({x0[1:0], (nb == 2'd1) ? 4'd0 : x1[7:4]});
        if (nb == 2'd1)
            chars_next[2] = PAD_CHAR;
        else if (grp_full)
            chars_next[2] = b64_char({x1[3:0], x2[7:6]});
        else
            chars_next[2] = b64_char({x1[3:0], 2'b00});
        chars_next[3] = grp_full ? b64_char(x2[5:0]) : PAD_CHAR;
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        pcnt_next      = pcnt_reg;
        hash_next      = hash_reg;
        idx_next       = idx_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg;
        digest_next    = digest_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    emit_next = end_of_message;
                    if (grp_full || end_of_message)
                        pcnt_next = 2'd0;
                    else
                    begin
                        pcnt_next = nb;
                        pend_next = {x0, x1};
                    end
                    if (has_chars)
                        state_next = S_FOLD;
                    else if (end_of_message)
                        state_next = S_HOLD;
                end
            end
            S_FOLD:
            begin
                hash_next = fold_hash;
                idx_next  = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    state_next = emit_reg ? S_HOLD : S_IDLE;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    digest_next    = hash_reg;
                    out_valid_next = 1'b1;
                    hash_next      = FNV_BASIS;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pcnt_reg      <= 2'd0;
            hash_reg      <= FNV_BASIS;
            idx_reg       <= 2'd0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pcnt_reg      <= pcnt_next;
            hash_reg      <= hash_next;
            idx_reg       <= idx_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        digest_reg <= digest_next;
        if (in_acc)
        begin
            chars_reg[0] <= chars_next[0];
            chars_reg[1] <= chars_next[1];
            chars_reg[2] <= chars_next[2];
            chars_reg[3] <= chars_next[3];
        end
    end

    // round counter wraps back to zero whenever the block is idle
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (idx_reg == 2'd0))
        else $error("round counter not cleared in idle");

    // a word without end marker never leads to a result
    a_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FOLD && idx_reg == 2'd3 && !emit_reg) |=>
        (state_reg == S_IDLE))
        else $error("rounds finished without end marker but did not return to idle");

    // loading the digest restarts the hash and presents the result
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid_reg && hash_reg == FNV_BASIS))
        else $error("digest load did not restart the hash");

endmodule

// File: rtl/b64fnv_fold.sv
// ----------------------------------------------------------------------------
// b64fnv_fold
// one fnv-1a round: xor a character into the hash, multiply by the prime
// ----------------------------------------------------------------------------
module b64fnv_fold (
    input  b64fnv_pkg::hash_t hash_in,
    input  b64fnv_pkg::char_t char_in,
    output b64fnv_pkg::hash_t hash_out
);
    import b64fnv_pkg::*;

    hash_t x;

    // prime is 2^40 + 0x1b3, so the product is a short sum of shifts
    assign x = hash_in ^ {56'd0, char_in};
    assign hash_out = (x << 40) + (x << 8) + (x << 7) + (x << 5)
                    + (x << 4) + (x << 1) + x;

endmodule
